>>> src/arm_bcp_pkg.sv
// ----------------------------------------------------------------------------
// arm_bcp_pkg
// types, codes and helpers shared by the branch-subset pipeline core
// ----------------------------------------------------------------------------
package arm_bcp_pkg;

   typedef logic [31:0] word_type;
   typedef logic [4:0]  mode_type;

   typedef enum logic [1:0] {
      ST_FLUSH   = 2'd0,
      ST_FETCH   = 2'd1,
      ST_DECODE  = 2'd2,
      ST_EXECUTE = 2'd3
   } stage_type;

   typedef enum logic [1:0] {
      CL_B   = 2'd0,
      CL_BL  = 2'd1,
      CL_BX  = 2'd2,
      CL_UND = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_DONE   = 2'd1,
      EV_BRANCH = 2'd2,
      EV_UND    = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      KIND_USR  = 3'd0,
      KIND_FIQ  = 3'd1,
      KIND_IRQ  = 3'd2,
      KIND_SVC  = 3'd3,
      KIND_ABT  = 3'd4,
      KIND_UND  = 3'd5,
      KIND_NONE = 3'd6
   } kind_type;

   localparam mode_type MODE_USR = 5'h10;
   localparam mode_type MODE_FIQ = 5'h11;
   localparam mode_type MODE_IRQ = 5'h12;
   localparam mode_type MODE_SVC = 5'h13;
   localparam mode_type MODE_ABT = 5'h17;
   localparam mode_type MODE_UND = 5'h1b;
   localparam mode_type MODE_SYS = 5'h1f;

   // flag vector bits
   localparam int FL_N = 6;
   localparam int FL_Z = 5;
   localparam int FL_C = 4;
   localparam int FL_V = 3;
   localparam int FL_I = 2;
   localparam int FL_F = 1;
   localparam int FL_T = 0;

   localparam word_type BX_MASK      = 32'h0ffffff0;
   localparam word_type BX_PATTERN   = 32'h012fff10;
   localparam word_type UND_VECTOR   = 32'h00000004;
   localparam word_type BOOT_PC      = 32'h08000000;
   localparam word_type BOOT_SP      = 32'h03007f00;
   localparam word_type BOOT_IRQ_SP  = 32'h03007fa0;
   localparam word_type BOOT_SVC_SP  = 32'h03007fe0;
   localparam word_type THUMB_ALIGN  = 32'hfffffffe;
   localparam word_type ARM_ALIGN    = 32'hfffffffc;
   localparam logic [11:0] BR_MASK   = 12'he00;
   localparam logic [11:0] BR_CODE   = 12'ha00;
   localparam logic [11:0] BX_CODE   = 12'h121;

   localparam logic [1:0] CSR_SKIP_BOOT = 2'd0;

   typedef struct packed {
      word_type  fetch_address;
      logic      fetch_halfword;
      word_type  cpsr_value;
      word_type  spsr_value;
      word_type  peek_value;
      event_type event_code;
   } result_type;

   function automatic kind_type mode_kind(input mode_type m);
      kind_type k;
      case (m)
         5'h00, MODE_USR, MODE_SYS: k = KIND_USR;
         5'h01, MODE_FIQ:           k = KIND_FIQ;
         5'h02, MODE_IRQ:           k = KIND_IRQ;
         5'h03, MODE_SVC:           k = KIND_SVC;
         MODE_ABT:                  k = KIND_ABT;
         MODE_UND:                  k = KIND_UND;
         default:                   k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic cond_pass(input logic [3:0] c, input logic [6:0] f);
      logic n, z, cf, v, p;
      n  = f[FL_N];
      z  = f[FL_Z];
      cf = f[FL_C];
      v  = f[FL_V];
      case (c)
         4'd0:    p = z;
         4'd1:    p = !z;
         4'd2:    p = cf;
         4'd3:    p = !cf;
         4'd4:    p = n;
         4'd5:    p = !n;
         4'd6:    p = v;
         4'd7:    p = !v;
         4'd8:    p = cf && !z;
         4'd9:    p = !cf || z;
         4'd10:   p = (n == v);
         4'd11:   p = (n != v);
         4'd12:   p = !z && (n == v);
         4'd13:   p = z || (n != v);
         4'd14:   p = 1'b1;
         default: p = 1'b0;
      endcase
      return p;
   endfunction

   function automatic word_type make_cpsr(input logic [6:0] f, input mode_type m);
      return {f[FL_N], f[FL_Z], f[FL_C], f[FL_V], 20'd0, f[FL_I], f[FL_F], f[FL_T], m};
   endfunction

   function automatic word_type branch_offset(input word_type w);
      return {{6{w[23]}}, w[23:0], 2'b00};
   endfunction

endpackage

>>> src/arm_bcp_core.sv
// ----------------------------------------------------------------------------
// arm_bcp_core
// architectural state of the core and the combinational step logic
// ----------------------------------------------------------------------------
module arm_bcp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   op,
   input  arm_bcp_pkg::word_type  fetch_data,
   input  logic [3:0]             peek_index,
   input  logic                   skip_boot,
   output arm_bcp_pkg::result_type result
);
   import arm_bcp_pkg::*;

   word_type  vis_ff [16];
   word_type  vis_in [16];
   word_type  usr_ff [7];
   word_type  usr_in [7];
   word_type  fiq_ff [7];
   word_type  fiq_in [7];
   word_type  irq_ff [2];
   word_type  irq_in [2];
   word_type  svc_ff [2];
   word_type  svc_in [2];
   word_type  abt_ff [2];
   word_type  abt_in [2];
   word_type  und_ff [2];
   word_type  und_in [2];
   word_type  sav_ff [5];
   word_type  sav_in [5];
   logic [6:0] flags_ff, flags_in;
   mode_type  mode_ff, mode_in;
   stage_type stage_ff, stage_in;
   word_type  fetched_ff, fetched_in;
   word_type  decoded_ff, decoded_in;
   class_type class_ff, class_in;
   event_type event_in;

   always_comb begin
      logic     do_jump;
      logic     do_und;
      word_type jaddr;
      word_type pc;
      word_type old_cpsr;
      word_type bx_val;
      kind_type k;
      logic [11:0] idx;
      vis_in     = vis_ff;
      usr_in     = usr_ff;
      fiq_in     = fiq_ff;
      irq_in     = irq_ff;
      svc_in     = svc_ff;
      abt_in     = abt_ff;
      und_in     = und_ff;
      sav_in     = sav_ff;
      flags_in   = flags_ff;
      mode_in    = mode_ff;
      stage_in   = stage_ff;
      fetched_in = fetched_ff;
      decoded_in = decoded_ff;
      class_in   = class_ff;
      event_in   = EV_NONE;
      do_jump    = 1'b0;
      do_und     = 1'b0;
      jaddr      = '0;
      pc         = vis_ff[15];
      old_cpsr   = make_cpsr(flags_ff, mode_ff);
      bx_val     = vis_ff[decoded_ff[3:0]];
      k          = mode_kind(mode_ff);
      idx        = '0;
      if (op) begin
         for (int i = 0; i < 16; i++) vis_in[i] = '0;
         for (int i = 0; i < 7; i++) begin
            usr_in[i] = '0;
            fiq_in[i] = '0;
         end
         for (int i = 0; i < 2; i++) begin
            irq_in[i] = '0;
            svc_in[i] = '0;
            abt_in[i] = '0;
            und_in[i] = '0;
         end
         for (int i = 0; i < 5; i++) sav_in[i] = '0;
         flags_in   = '0;
         stage_in   = ST_FLUSH;
         fetched_in = '0;
         decoded_in = '0;
         class_in   = CL_UND;
         if (skip_boot) begin
            vis_in[13] = BOOT_SP;
            vis_in[15] = BOOT_PC;
            irq_in[0]  = BOOT_IRQ_SP;
            svc_in[0]  = BOOT_SVC_SP;
            mode_in    = MODE_SYS;
         end else begin
            mode_in    = MODE_SVC;
         end
      end else begin
         // execute
         if (stage_ff == ST_EXECUTE) begin
            if (flags_ff[FL_T]) begin
               do_und = 1'b1;
            end else if (!cond_pass(decoded_ff[31:28], flags_ff)) begin
               event_in = EV_DONE;
            end else begin
               case (class_ff)
                  CL_B: begin
                     jaddr   = pc + branch_offset(decoded_ff);
                     do_jump = 1'b1;
                  end
                  CL_BL: begin
                     vis_in[14] = pc - 32'd4;
                     jaddr      = pc + branch_offset(decoded_ff);
                     do_jump    = 1'b1;
                  end
                  CL_BX: begin
                     if ((decoded_ff & BX_MASK) != BX_PATTERN) begin
                        do_und = 1'b1;
                     end else begin
                        flags_in[FL_T] = bx_val[0];
                        jaddr          = bx_val;
                        do_jump        = 1'b1;
                     end
                  end
                  default: do_und = 1'b1;
               endcase
            end
            if (do_und) begin
               // bank out the current mode
               case (k)
                  KIND_USR: for (int i = 0; i < 7; i++) usr_in[i] = vis_ff[8+i];
                  KIND_FIQ: for (int i = 0; i < 7; i++) fiq_in[i] = vis_ff[8+i];
                  KIND_IRQ, KIND_SVC, KIND_ABT, KIND_UND: begin
                     for (int i = 0; i < 5; i++) usr_in[i] = vis_ff[8+i];
                     case (k)
                        KIND_IRQ: begin irq_in[0] = vis_ff[13]; irq_in[1] = vis_ff[14]; end
                        KIND_SVC: begin svc_in[0] = vis_ff[13]; svc_in[1] = vis_ff[14]; end
                        KIND_ABT: begin abt_in[0] = vis_ff[13]; abt_in[1] = vis_ff[14]; end
                        default:  begin und_in[0] = vis_ff[13]; und_in[1] = vis_ff[14]; end
                     endcase
                  end
                  default: ;
               endcase
               // bank in undefined mode
               for (int i = 0; i < 5; i++) vis_in[8+i] = usr_in[i];
               vis_in[13] = und_in[0];
               vis_in[14] = pc - (flags_ff[FL_T] ? 32'd2 : 32'd4);
               mode_in    = MODE_UND;
               sav_in[4]  = old_cpsr;
               flags_in[FL_T] = 1'b0;
               flags_in[FL_I] = 1'b1;
               jaddr   = UND_VECTOR;
               do_jump = 1'b1;
            end
            if (do_jump) begin
               vis_in[15] = jaddr & (flags_in[FL_T] ? THUMB_ALIGN : ARM_ALIGN);
               stage_in   = ST_FLUSH;
               event_in   = do_und ? EV_UND : EV_BRANCH;
            end else if (!do_und && event_in == EV_NONE) begin
               event_in = EV_DONE;
            end
         end
         // decode
         if (stage_in == ST_DECODE || stage_in == ST_EXECUTE) begin
            if (flags_in[FL_T]) begin
               decoded_in = {16'd0, fetched_ff[15:0]};
               class_in   = CL_UND;
            end else begin
               idx        = {fetched_ff[27:20], fetched_ff[7:4]};
               decoded_in = fetched_ff;
               if ((idx & BR_MASK) == BR_CODE) class_in = idx[8] ? CL_BL : CL_B;
               else if (idx == BX_CODE)        class_in = CL_BX;
               else                            class_in = CL_UND;
            end
         end
         // fetch
         if (stage_in != ST_FLUSH) begin
            if (flags_in[FL_T]) begin
               fetched_in = {16'd0, fetch_data[15:0]};
               vis_in[15] = vis_in[15] + 32'd2;
            end else begin
               fetched_in = fetch_data;
               vis_in[15] = vis_in[15] + 32'd4;
            end
         end
         if (stage_in != ST_EXECUTE) stage_in = stage_type'(stage_in + 2'd1);
      end
   end

   always_comb begin
      kind_type kn;
      kn = mode_kind(mode_in);
      result.fetch_address  = vis_in[15];
      result.fetch_halfword = flags_in[FL_T];
      result.cpsr_value     = make_cpsr(flags_in, mode_in);
      case (kn)
         KIND_USR:  result.spsr_value = make_cpsr(flags_in, mode_in);
         KIND_FIQ:  result.spsr_value = sav_in[0];
         KIND_IRQ:  result.spsr_value = sav_in[1];
         KIND_SVC:  result.spsr_value = sav_in[2];
         KIND_ABT:  result.spsr_value = sav_in[3];
         KIND_UND:  result.spsr_value = sav_in[4];
         default:   result.spsr_value = '0;
      endcase
      result.peek_value = vis_in[peek_index];
      result.event_code = event_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++)
            vis_ff[i] <= (i == 13) ? BOOT_SP : ((i == 15) ? BOOT_PC : 32'd0);
         for (int i = 0; i < 7; i++) begin
            usr_ff[i] <= '0;
            fiq_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            irq_ff[i] <= (i == 0) ? BOOT_IRQ_SP : 32'd0;
            svc_ff[i] <= (i == 0) ? BOOT_SVC_SP : 32'd0;
            abt_ff[i] <= '0;
            und_ff[i] <= '0;
         end
         for (int i = 0; i < 5; i++) sav_ff[i] <= '0;
         flags_ff   <= '0;
         mode_ff    <= MODE_SYS;
         stage_ff   <= ST_FLUSH;
         fetched_ff <= '0;
         decoded_ff <= '0;
         class_ff   <= CL_UND;
      end else if (step) begin
         vis_ff     <= vis_in;
         usr_ff     <= usr_in;
         fiq_ff     <= fiq_in;
         irq_ff     <= irq_in;
         svc_ff     <= svc_in;
         abt_ff     <= abt_in;
         und_ff     <= und_in;
         sav_ff     <= sav_in;
         flags_ff   <= flags_in;
         mode_ff    <= mode_in;
         stage_ff   <= stage_in;
         fetched_ff <= fetched_in;
         decoded_ff <= decoded_in;
         class_ff   <= class_in;
      end
   end

endmodule

>>> src/arm_branch_core_pipeline_top.sv
// ----------------------------------------------------------------------------
// arm_branch_core_pipeline_top
// three-stage core running the branch subset, one core cycle per beat
// ----------------------------------------------------------------------------
// each req beat runs one core cycle (tuser = 0) or resets the core (tuser = 1);
// tdata carries the word read at the last reported fetch address and the
// register number to report back. each req beat gives exactly one rsp beat
// with the new fetch address, Thumb flag, CPSR, SPSR, the chosen register
// and what the execute stage did.
// the step logic sits between the core state and the rsp register, so each
// rsp beat is registered. throughput is one beat per cycle, set by the single
// rsp register; req_tready drops only while a rsp beat is held by the receiver.
// reset empties the rsp register and puts the core in system mode at the
// cartridge entry with the boot stack pointers; the csr skip_boot register
// (address 0, reset 1) picks the start used by later core resets.
// ----------------------------------------------------------------------------
module arm_branch_core_pipeline_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // fetch_data[31:0], peek_index[35:32]
   input  logic         req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // fetch_address, fetch_halfword, cpsr_value,
                                     // spsr_value, peek_value, event_code
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import arm_bcp_pkg::*;

   logic       skip_ff, skip_in;
   logic       valid_ff, valid_in;
   result_type res_ff, res_in;
   logic       accept;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2:1] == CSR_SKIP_BOOT) ? {31'd0, skip_ff} : 32'd0;
   assign skip_in = (csr_psel && csr_penable && csr_pwrite && csr_paddr[2:1] == CSR_SKIP_BOOT)
                    ? csr_pwdata[0] : skip_ff;

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept || (valid_ff && !rsp_tready);

   arm_bcp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .op         (req_tuser),
      .fetch_data (req_tdata[31:0]),
      .peek_index (req_tdata[35:32]),
      .skip_boot  (skip_ff),
      .result     (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         skip_ff  <= skip_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, res_ff.event_code, res_ff.peek_value, res_ff.spsr_value,
                        res_ff.cpsr_value, res_ff.fetch_halfword, res_ff.fetch_address};

endmodule

>>> src/arm_bcp_checker.sv
// ----------------------------------------------------------------------------
// arm_bcp_checker
// port-level checks on the pipeline top, bound to it
// ----------------------------------------------------------------------------
module arm_bcp_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("req beat gave no rsp beat");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty rsp register");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled rsp beat changed");

endmodule

bind arm_branch_core_pipeline_top arm_bcp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
